@@ design/ec_pkg.sv @@
// ----------------------------------------------------------------------------
// ec_pkg
// Shared types and constants for the epoch to calendar converter: stage
// count, stage advance struct, reciprocal constants and calendar tables.
// ----------------------------------------------------------------------------
package ec_pkg;

	// pipeline depth, input register is stage 1, result register is the last
	localparam int unsigned STAGES = 7;

	// default length of one time zone step in seconds
	localparam int unsigned ZONE_UNIT_DEFAULT = 3600;

	// field widths
	localparam int unsigned EPOCH_W = 32;
	localparam int unsigned TZ_W    = 5;
	localparam int unsigned DAYS_W  = 16;
	localparam int unsigned SECS_W  = 17;
	localparam int unsigned CYC_W   = 6;
	localparam int unsigned R_W     = 11;
	localparam int unsigned DOY_W   = 9;
	localparam int unsigned REMH_W  = 12;

	// legal time zone range
	localparam logic signed [TZ_W-1:0] TZ_MIN = -5'sd12;
	localparam logic signed [TZ_W-1:0] TZ_MAX = 5'sd14;

	// seconds to days: (t >> 7) / 675, reciprocal exact for 25-bit numerators
	localparam int unsigned   DAY_PRE_SH   = 7;
	localparam logic [25:0]   DAY_RECIP    = 26'd50903317;
	localparam int unsigned   DAY_RECIP_SH = 35;
	localparam logic [16:0]   SECS_PER_DAY = 17'd86400;

	// days to four-year cycles, exact for 16-bit numerators
	localparam logic [15:0]   CYC_RECIP    = 16'd45934;
	localparam int unsigned   CYC_RECIP_SH = 26;
	localparam logic [15:0]   DAYS_PER_CYC = 16'd1461;

	// weekday, divide by seven, exact for 16-bit numerators
	localparam logic [16:0]   WK_RECIP     = 17'd74899;
	localparam int unsigned   WK_RECIP_SH  = 19;
	localparam logic [15:0]   EPOCH_WDAY   = 16'd4;
	localparam logic [15:0]   DAYS_PER_WK  = 16'd7;

	// seconds of day to hours, exact for 17-bit numerators
	localparam logic [17:0]   HR_RECIP     = 18'd149131;
	localparam int unsigned   HR_RECIP_SH  = 29;
	localparam logic [16:0]   SECS_PER_HR  = 17'd3600;

	// seconds of hour to minutes, exact for 12-bit numerators
	localparam logic [12:0]   MIN_RECIP    = 13'd4370;
	localparam int unsigned   MIN_RECIP_SH = 18;
	localparam logic [11:0]   SECS_PER_MIN = 12'd60;

	localparam logic [11:0]   YEAR_BASE    = 12'd1970;

	// first day of each year of a four-year cycle, third year is leap
	localparam logic [R_W-1:0] CYCLE_START [0:4] = '{
		11'd0, 11'd365, 11'd730, 11'd1096, 11'd1461
	};

	// first day of each month in a common year
	localparam logic [DOY_W-1:0] MONTH_START [0:12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
		9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
	};

	// per-stage advance strobes
	typedef struct packed {
		logic [STAGES:1] en;
	} ec_adv_t;

	// first day of month m (0 based), shifted by one after february in leap years
	function automatic logic [DOY_W-1:0] month_base(input logic [3:0] m, input logic leap);
		logic [DOY_W-1:0] base;
		base = MONTH_START[m];
		if (m >= 4'd2 && leap) begin
			base = base + 9'd1;
		end
		return base;
	endfunction

endpackage

@@ design/ec_zone_reg.sv @@
// ----------------------------------------------------------------------------
// ec_zone_reg
// Time zone configuration register. Writes outside the legal range are
// dropped and the previous value is kept.
// ----------------------------------------------------------------------------
module ec_zone_reg import ec_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic        [TZ_W-1:0] cfg_wr_data,
	output logic signed [TZ_W-1:0] zone_hours
);

	logic signed [TZ_W-1:0] wr_val;
	logic                   wr_legal;
	logic signed [TZ_W-1:0] tz_q;

	// range check on the written value
	assign wr_val   = $signed(cfg_wr_data);
	assign wr_legal = (wr_val >= TZ_MIN) && (wr_val <= TZ_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tz_q <= '0;
		end else if (cfg_wr_en && wr_legal) begin
			tz_q <= wr_val;
		end
	end

	assign zone_hours = tz_q;

endmodule

@@ design/ec_pipe_ctrl.sv @@
// ----------------------------------------------------------------------------
// ec_pipe_ctrl
// Valid tracking and per-stage advance for the conversion pipeline. A stage
// loads when it is empty or its content moves on, so bubbles are squeezed
// out and a stalled result does not block earlier stages from filling.
// ----------------------------------------------------------------------------
module ec_pipe_ctrl import ec_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output ec_adv_t adv
);

	logic [STAGES:1] valid_q;
	logic [STAGES:1] en;

	// ready ripples back from the result register
	always_comb begin
		en[STAGES] = !valid_q[STAGES] || out_ready;
		for (int k = STAGES - 1; k >= 1; k--) begin
			en[k] = !valid_q[k] || en[k+1];
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[1]) begin
				valid_q[1] <= in_valid;
			end
			for (int k = 2; k <= STAGES; k++) begin
				if (en[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign adv.en    = en;
	assign in_ready  = en[1];
	assign out_valid = valid_q[STAGES];

endmodule

@@ design/ec_day_split.sv @@
// ----------------------------------------------------------------------------
// ec_day_split
// Stages 1 to 3: applies the zone offset, then splits local time into a
// day count and the seconds within that day.
// ----------------------------------------------------------------------------
module ec_day_split import ec_pkg::*; #(
	parameter int unsigned ZONE_UNIT_SECONDS = ZONE_UNIT_DEFAULT
) (
	input  logic                     clk,
	input  ec_adv_t                  adv,
	input  logic       [EPOCH_W-1:0] epoch_seconds,
	input  logic                     use_utc,
	input  logic signed [TZ_W-1:0]   zone_hours,
	output logic       [DAYS_W-1:0]  days_s3,
	output logic       [SECS_W-1:0]  secs_s3,
	output logic signed [TZ_W-1:0]   tz_s3
);

	localparam int unsigned ZU_W  = $clog2(ZONE_UNIT_SECONDS + 1) + 1;
	localparam int unsigned OFF_W = ZU_W + TZ_W;
	localparam int unsigned PROD_W = DAY_RECIP_SH + DAYS_W;
	localparam logic signed [ZU_W-1:0] ZONE_UNIT = ZU_W'(ZONE_UNIT_SECONDS);

	logic signed [TZ_W-1:0]    zone_sel;
	logic signed [OFF_W-1:0]   zone_off;
	logic        [EPOCH_W-1:0] offset;

	logic        [EPOCH_W-1:0] t_s1;
	logic signed [TZ_W-1:0]    tz_s1;
	logic        [PROD_W-1:0]  day_prod_s2;
	logic        [SECS_W-1:0]  t_lo_s2;
	logic signed [TZ_W-1:0]    tz_s2;
	logic        [DAYS_W-1:0]  days;

	// zone offset in seconds, sign extended to the time width
	assign zone_sel = use_utc ? '0 : zone_hours;
	assign zone_off = OFF_W'(zone_sel) * OFF_W'(ZONE_UNIT);
	assign offset   = {{(EPOCH_W - OFF_W){zone_off[OFF_W-1]}}, zone_off};

	// stage 1: local time, wraps modulo 2^32
	always_ff @(posedge clk) begin
		if (adv.en[1]) begin
			t_s1  <= epoch_seconds + offset;
			tz_s1 <= zone_sel;
		end
	end

	// stage 2: reciprocal product for the day count
	always_ff @(posedge clk) begin
		if (adv.en[2]) begin
			day_prod_s2 <= PROD_W'(t_s1[EPOCH_W-1:DAY_PRE_SH]) * PROD_W'(DAY_RECIP);
			t_lo_s2     <= t_s1[SECS_W-1:0];
			tz_s2       <= tz_s1;
		end
	end

	assign days = day_prod_s2[DAY_RECIP_SH +: DAYS_W];

	// stage 3: day count and seconds of day, remainder fits in 17 bits
	always_ff @(posedge clk) begin
		if (adv.en[3]) begin
			days_s3 <= days;
			secs_s3 <= t_lo_s2 - SECS_W'(days * SECS_PER_DAY);
			tz_s3   <= tz_s2;
		end
	end

endmodule

@@ design/ec_cal_fields.sv @@
// ----------------------------------------------------------------------------
// ec_cal_fields
// Stages 4 to 7: breaks the day count into year, day of year, month, day of
// month and weekday, and the seconds of day into hour, minute and second.
// ----------------------------------------------------------------------------
module ec_cal_fields import ec_pkg::*; (
	input  logic                    clk,
	input  ec_adv_t                 adv,
	input  logic       [DAYS_W-1:0] days_s3,
	input  logic       [SECS_W-1:0] secs_s3,
	input  logic signed [TZ_W-1:0]  tz_s3,
	output logic       [11:0]       year,
	output logic       [3:0]        month,
	output logic       [4:0]        day_of_month,
	output logic       [DOY_W-1:0]  day_of_year,
	output logic       [2:0]        weekday,
	output logic       [4:0]        hour,
	output logic       [5:0]        minute,
	output logic       [5:0]        second,
	output logic signed [TZ_W-1:0]  zone_applied
);

	// stage 4 registers
	logic        [31:0]       cyc_prod_s4;
	logic        [31:0]       wk_prod_s4;
	logic        [33:0]       hr_prod_s4;
	logic        [DAYS_W-1:0] days_s4;
	logic        [DAYS_W-1:0] dp4_s4;
	logic        [SECS_W-1:0] secs_s4;
	logic signed [TZ_W-1:0]   tz_s4;
	logic        [DAYS_W-1:0] dp4;

	// stage 5 registers
	logic        [CYC_W-1:0]  cycles_s5;
	logic        [R_W-1:0]    r_s5;
	logic        [2:0]        wday_s5;
	logic        [4:0]        hour_s5;
	logic        [REMH_W-1:0] remh_s5;
	logic signed [TZ_W-1:0]   tz_s5;
	logic        [CYC_W-1:0]  cycles;
	logic        [12:0]       q7;
	logic        [4:0]        hr;

	// stage 6 registers
	logic        [11:0]       year_s6;
	logic        [DOY_W-1:0]  doy0_s6;
	logic                     leap_s6;
	logic        [23:0]       min_prod_s6;
	logic        [REMH_W-1:0] remh_s6;
	logic        [2:0]        wday_s6;
	logic        [4:0]        hour_s6;
	logic signed [TZ_W-1:0]   tz_s6;
	logic        [1:0]        yi;

	// stage 7 logic
	logic        [3:0]        m;
	logic        [5:0]        mins;

	assign dp4 = days_s3 + EPOCH_WDAY;

	// stage 4: reciprocal products for cycles, weekday and hour
	always_ff @(posedge clk) begin
		if (adv.en[4]) begin
			cyc_prod_s4 <= 32'(days_s3) * 32'(CYC_RECIP);
			wk_prod_s4  <= 32'(dp4) * 32'(WK_RECIP);
			hr_prod_s4  <= 34'(secs_s3) * 34'(HR_RECIP);
			days_s4     <= days_s3;
			dp4_s4      <= dp4;
			secs_s4     <= secs_s3;
			tz_s4       <= tz_s3;
		end
	end

	assign cycles = cyc_prod_s4[CYC_RECIP_SH +: CYC_W];
	assign q7     = wk_prod_s4[WK_RECIP_SH +: 13];
	assign hr     = hr_prod_s4[HR_RECIP_SH +: 5];

	// stage 5: quotients and remainders
	always_ff @(posedge clk) begin
		if (adv.en[5]) begin
			cycles_s5 <= cycles;
			r_s5      <= R_W'(days_s4 - 16'(cycles * DAYS_PER_CYC));
			wday_s5   <= 3'(dp4_s4 - 16'(q7 * DAYS_PER_WK));
			hour_s5   <= hr;
			remh_s5   <= REMH_W'(secs_s4 - 17'(hr * SECS_PER_HR));
			tz_s5     <= tz_s4;
		end
	end

	// year within the four-year cycle
	always_comb begin
		yi = 2'd0;
		if (r_s5 >= CYCLE_START[1]) begin
			yi = 2'd1;
		end
		if (r_s5 >= CYCLE_START[2]) begin
			yi = 2'd2;
		end
		if (r_s5 >= CYCLE_START[3]) begin
			yi = 2'd3;
		end
	end

	// stage 6: year, day of year, minute product
	always_ff @(posedge clk) begin
		if (adv.en[6]) begin
			year_s6     <= YEAR_BASE + 12'({cycles_s5, 2'b00}) + 12'(yi);
			doy0_s6     <= DOY_W'(r_s5 - CYCLE_START[{1'b0, yi}]);
			leap_s6     <= (yi == 2'd2);
			min_prod_s6 <= 24'(remh_s5) * 24'(MIN_RECIP);
			remh_s6     <= remh_s5;
			wday_s6     <= wday_s5;
			hour_s6     <= hour_s5;
			tz_s6       <= tz_s5;
		end
	end

	// month search, month starts rise so the last hit wins
	always_comb begin
		m = 4'd0;
		for (int k = 1; k <= 11; k++) begin
			if (doy0_s6 >= month_base(4'(k), leap_s6)) begin
				m = 4'(k);
			end
		end
	end

	assign mins = min_prod_s6[MIN_RECIP_SH +: 6];

	// stage 7: result register
	always_ff @(posedge clk) begin
		if (adv.en[7]) begin
			year         <= year_s6;
			month        <= m + 4'd1;
			day_of_month <= 5'(doy0_s6 - month_base(m, leap_s6) + 9'd1);
			day_of_year  <= doy0_s6 + 9'd1;
			weekday      <= wday_s6;
			hour         <= hour_s6;
			minute       <= mins;
			second       <= 6'(remh_s6 - 12'(mins * SECS_PER_MIN));
			zone_applied <= tz_s6;
		end
	end

endmodule

@@ design/epoch_to_calendar.sv @@
// ----------------------------------------------------------------------------
// epoch_to_calendar
// Converts seconds since 1970-01-01 00:00:00 UTC, optionally shifted by the
// configured time zone, into calendar date, weekday and time of day.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------------
//   input    | in_valid / in_ready     | epoch_seconds, use_utc
//   output   | out_valid / out_ready   | year .. second, zone_applied
//   config   | cfg_wr_en               | cfg_wr_data (time zone, hours)
//
// One word per cycle while the output is not stalled; a word passes from the input
// register through the stage registers to the result register, a depth set by the
// chain of reciprocal multiplies.
// Reset clears the stage valid bits and sets the time zone to 0.
// A stalled result holds only the stages that are full behind it; empty
// stages keep filling, so in_ready stays high until the pipeline is full.
// ----------------------------------------------------------------------------
module epoch_to_calendar import ec_pkg::*; #(
	parameter int unsigned ZONE_UNIT_SECONDS = ZONE_UNIT_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic       [TZ_W-1:0]    cfg_wr_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic       [EPOCH_W-1:0] epoch_seconds,
	input  logic                     use_utc,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic       [11:0]        year,
	output logic       [3:0]         month,
	output logic       [4:0]         day_of_month,
	output logic       [DOY_W-1:0]   day_of_year,
	output logic       [2:0]         weekday,
	output logic       [4:0]         hour,
	output logic       [5:0]         minute,
	output logic       [5:0]         second,
	output logic signed [TZ_W-1:0]   zone_applied
);

	ec_adv_t                 adv;
	logic signed [TZ_W-1:0]  zone_hours;
	logic       [DAYS_W-1:0] days_s3;
	logic       [SECS_W-1:0] secs_s3;
	logic signed [TZ_W-1:0]  tz_s3;

	// time zone register
	ec_zone_reg u_zone (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.zone_hours  (zone_hours)
	);

	// stage valid and advance control
	ec_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.adv       (adv)
	);

	// zone offset and day split
	ec_day_split #(
		.ZONE_UNIT_SECONDS (ZONE_UNIT_SECONDS)
	) u_day (
		.clk           (clk),
		.adv           (adv),
		.epoch_seconds (epoch_seconds),
		.use_utc       (use_utc),
		.zone_hours    (zone_hours),
		.days_s3       (days_s3),
		.secs_s3       (secs_s3),
		.tz_s3         (tz_s3)
	);

	// calendar and clock fields
	ec_cal_fields u_cal (
		.clk          (clk),
		.adv          (adv),
		.days_s3      (days_s3),
		.secs_s3      (secs_s3),
		.tz_s3        (tz_s3),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month),
		.day_of_year  (day_of_year),
		.weekday      (weekday),
		.hour         (hour),
		.minute       (minute),
		.second       (second),
		.zone_applied (zone_applied)
	);

endmodule

@@ tb/sv/tb_epoch_to_calendar.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epoch_to_calendar
// Self-checking bench for the epoch to calendar converter. Every accepted
// timestamp is run through a local calendar predictor, and each result word
// is compared field by field with the oldest prediction. The stimulus covers
// range ends, leap and cycle boundaries, zone wrap, rejected zone writes,
// random traffic under four idle mixes, and a long output stall.
// ----------------------------------------------------------------------------
module tb_epoch_to_calendar import ec_pkg::*; ();

	localparam int unsigned ZONE_STEP      = ZONE_UNIT_DEFAULT;
	localparam int unsigned SECS_DAY       = 86400;
	localparam int unsigned DAYS_QUAD      = 1461;
	localparam int          WATCHDOG_LIMIT = 10000;
	localparam int          HOLD_CYCLES    = 300;

	// predicted calendar fields, same order as the result ports
	typedef struct packed {
		logic [11:0]            year;
		logic [3:0]             month;
		logic [4:0]             mday;
		logic [DOY_W-1:0]       yday;
		logic [2:0]             wday;
		logic [4:0]             hour;
		logic [5:0]             minute;
		logic [5:0]             sec;
		logic signed [TZ_W-1:0] zone;
	} cal_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_wr_en;
	logic       [TZ_W-1:0]    cfg_wr_data;
	logic                     in_valid;
	logic                     in_ready;
	logic       [EPOCH_W-1:0] epoch_seconds;
	logic                     use_utc;
	logic                     out_valid;
	logic                     out_ready;
	logic       [11:0]        year;
	logic       [3:0]         month;
	logic       [4:0]         day_of_month;
	logic       [DOY_W-1:0]   day_of_year;
	logic       [2:0]         weekday;
	logic       [4:0]         hour;
	logic       [5:0]         minute;
	logic       [5:0]         second;
	logic signed [TZ_W-1:0]   zone_applied;

	// local copy of the zone register
	logic signed [TZ_W-1:0] zone_now;

	int unsigned year_first [0:4]  = '{0, 365, 730, 1096, 1461};
	int unsigned month_first [0:12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
		304, 334, 365};

	cal_t pending_dates [$];
	cal_t seen;

	int mismatches;
	int words_sent;
	int utc_words;
	int results_checked;
	int quiet_cycles;
	int sender_idle_pct;
	int receiver_stall_pct;
	int hold_left;
	bit hold_go;

	epoch_to_calendar DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.epoch_seconds(epoch_seconds),
		.use_utc      (use_utc),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month),
		.day_of_year  (day_of_year),
		.weekday      (weekday),
		.hour         (hour),
		.minute       (minute),
		.second       (second),
		.zone_applied (zone_applied)
	);

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// calendar predictor: zone shift with 32-bit wrap, then day, cycle, year, month split
	function automatic cal_t to_calendar(input logic [31:0] secs_in, input logic utc);
		cal_t        c;
		int          tz;
		logic [31:0] shifted;
		int unsigned days, sod, quad, rem, yi, doy0, leap, m;
		tz = utc ? 0 : int'(zone_now);
		shifted = secs_in + 32'(tz * int'(ZONE_STEP));
		days = shifted / SECS_DAY;
		sod = shifted % SECS_DAY;
		quad = days / DAYS_QUAD;
		rem = days % DAYS_QUAD;
		yi = 0;
		while (yi < 3 && rem >= year_first[yi + 1])
			yi++;
		doy0 = rem - year_first[yi];
		// only the third year of a cycle has february 29
		leap = (yi == 2) ? 1 : 0;
		m = 0;
		while (m < 11 && doy0 >= month_first[m + 1] + ((m + 1 >= 2) ? leap : 0))
			m++;
		c.year   = 12'(1970 + quad * 4 + yi);
		c.month  = 4'(m + 1);
		c.mday   = 5'(doy0 - (month_first[m] + ((m >= 2) ? leap : 0)) + 1);
		c.yday   = 9'(doy0 + 1);
		c.wday   = 3'((days + 4) % 7);
		c.hour   = 5'(sod / 3600);
		c.minute = 6'((sod % 3600) / 60);
		c.sec    = 6'(sod % 60);
		c.zone   = 5'(tz);
		return c;
	endfunction

	// one line per mismatch
	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch at result %0d: %s got %0d, expected %0d", results_checked, what,
			got, want);
		mismatches++;
	endtask

	task automatic compare_date(input cal_t got, input cal_t want);
		if (got.year !== want.year) report("year", got.year, want.year);
		if (got.month !== want.month) report("month", got.month, want.month);
		if (got.mday !== want.mday) report("day_of_month", got.mday, want.mday);
		if (got.yday !== want.yday) report("day_of_year", got.yday, want.yday);
		if (got.wday !== want.wday) report("weekday", got.wday, want.wday);
		if (got.hour !== want.hour) report("hour", got.hour, want.hour);
		if (got.minute !== want.minute) report("minute", got.minute, want.minute);
		if (got.sec !== want.sec) report("second", got.sec, want.sec);
		if (got.zone !== want.zone) report("zone_applied", got.zone, want.zone);
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen = {year, month, day_of_month, day_of_year, weekday, hour, minute, second,
				zone_applied};
			if (pending_dates.size() == 0)
				report("result word with nothing pending", 1, 0);
			else
				compare_date(seen, pending_dates.pop_front());
			results_checked++;
		end
	end

	// receiver: random stalls, plus a long hold when requested
	always @(posedge clk) begin
		if (hold_go) begin
			hold_go = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved in %0d cycles", WATCHDOG_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	// offer one word, hold it until accepted, then record its prediction
	task automatic send_word(input logic [31:0] e, input logic u);
		int gap;
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		epoch_seconds <= e;
		use_utc <= u;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_dates.push_back(to_calendar(e, u));
		words_sent++;
		if (u)
			utc_words++;
	endtask

	// stop offering, wait for every pending result, then let the pipe settle
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (STAGES + 2) @(posedge clk);
	endtask

	// zone write while idle; out-of-range values leave the register alone
	task automatic write_zone(input logic [TZ_W-1:0] v);
		drain_pipeline();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if ($signed(v) >= TZ_MIN && $signed(v) <= TZ_MAX)
			zone_now = $signed(v);
	endtask

	// random timestamp, weighted toward day, year and range boundaries
	function automatic logic [31:0] rand_epoch();
		int unsigned d, y;
		case ($urandom_range(3))
			0: return $urandom;
			1: begin
				d = $urandom_range(49709);
				return d * SECS_DAY + ($urandom_range(1) ? $urandom_range(5)
					: SECS_DAY - 1 - $urandom_range(5));
			end
			2: begin
				y = $urandom_range(136);
				d = 365 * y + (y + 1) / 4;
				return 32'(d * SECS_DAY) + 32'($urandom_range(7200)) - 32'd3600;
			end
			default: return $urandom_range(1) ? 32'hFFFF_FFFF - $urandom_range(200000)
				: 32'($urandom_range(200000));
		endcase
	endfunction

	// zone is 0 straight after reset
	task automatic test_reset_zone();
		send_word(32'd0, 1'b0);
		send_word(32'd86399, 1'b0);
	endtask

	task automatic test_epoch_extremes();
		send_word(32'd0, 1'b1);
		send_word(32'hFFFF_FFFF, 1'b1);
		send_word(32'd86399, 1'b1);
		send_word(32'd86400, 1'b1);
	endtask

	// leap days, end of leap year, last day of a four-year cycle, 2100 as leap
	task automatic test_calendar_edges();
		send_word(32'd68169600, 1'b1);
		send_word(32'd94608000, 1'b1);
		send_word(32'd94694399, 1'b1);
		send_word(32'd126230399, 1'b1);
		send_word(32'd126230400, 1'b1);
		send_word(32'd951782400, 1'b1);
		send_word(32'd4107542400, 1'b1);
	endtask

	// local time wraps below zero and past the top of the range
	task automatic test_zone_wrap();
		write_zone(-5'sd12);
		send_word(32'd0, 1'b0);
		send_word(32'd0, 1'b1);
		write_zone(5'sd14);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b1);
	endtask

	// writes outside -12..14 are dropped
	task automatic test_zone_rejected();
		write_zone(5'sd5);
		write_zone(5'sd15);
		write_zone(-5'sd13);
		write_zone(-5'sd16);
		send_word(32'd1000000000, 1'b0);
		send_word(32'd1000000000, 1'b1);
	endtask

	task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		repeat (n) send_word(rand_epoch(), ($urandom_range(3) == 0));
	endtask

	// long output hold while the sender keeps offering, then a full drain
	task automatic test_output_hold();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_go = 1'b1;
		repeat (40) send_word(rand_epoch(), ($urandom_range(3) == 0));
		drain_pipeline();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		epoch_seconds = '0;
		use_utc = 1'b0;
		out_ready = 1'b0;
		zone_now = '0;
		mismatches = 0;
		words_sent = 0;
		utc_words = 0;
		results_checked = 0;
		quiet_cycles = 0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_left = 0;
		hold_go = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_zone();
		test_epoch_extremes();
		test_calendar_edges();
		test_zone_wrap();
		test_zone_rejected();

		write_zone(-5'sd12);
		test_random_traffic(470, 0, 0);
		write_zone(5'sd14);
		test_random_traffic(470, 75, 0);
		write_zone(5'($urandom_range(26) - 12));
		test_random_traffic(470, 0, 75);
		write_zone(5'($urandom));
		test_random_traffic(470, 7, 7);
		test_output_hold();
		drain_pipeline();

		$display("covered %0d words (%0d in utc mode), %0d results checked", words_sent,
			utc_words, results_checked);
		$display("zones -12, 0, 14 and random, dropped zone writes, four idle mixes, long hold");
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ sim.f @@
design/ec_pkg.sv
design/ec_zone_reg.sv
design/ec_pipe_ctrl.sv
design/ec_day_split.sv
design/ec_cal_fields.sv
design/epoch_to_calendar.sv
tb/sv/tb_epoch_to_calendar.sv
